[sv/waypoint_dwell_sequencer_assert.svh]
// -----------------------------------------------------------------------------
// waypoint dwell sequencer assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// -----------------------------------------------------------------------------
`ifndef WAYPOINT_DWELL_SEQUENCER_ASSERT_SVH
`define WAYPOINT_DWELL_SEQUENCER_ASSERT_SVH

`ifndef SYNTH
`define WDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`else
`define WDS_ASSERT(label, clk, rst, prop, msg)
`define WDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`endif

`endif

[sv/wds_pkg.sv]
// -----------------------------------------------------------------------------
// wds_pkg
// shared types and constants of the waypoint dwell sequencer
// -----------------------------------------------------------------------------
package wds_pkg;

   localparam int MAX_WAYPOINTS         = 5;
   localparam int DEFAULT_NUM_WAYPOINTS = 5;
   localparam int WP_IDX_W              = 3;
   localparam int HOLD_W                = 16;
   localparam int COORD_W               = 8;
   localparam int WP_W                  = 2 * COORD_W;
   localparam int CSR_DATA_W            = 16;

   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET = 16'd100;
   localparam logic [COORD_W-1:0] IMAGE_SIZE_RESET = 8'd240;

   typedef enum logic [1:0] {
      FUNC_TICK   = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_STOP   = 2'd2,
      FUNC_PACKET = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      LOAD_NONE   = 2'd0,
      LOAD_SET    = 2'd1,
      LOAD_UPDATE = 2'd2
   } load_type;

   typedef enum logic [0:0] {
      CSR_HOLD_TICKS = 1'b0,
      CSR_IMAGE_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         func;
      logic               reached;
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
      logic [COORD_W-1:0] x2;
      logic [COORD_W-1:0] y2;
      logic [COORD_W-1:0] x3;
      logic [COORD_W-1:0] y3;
      logic [COORD_W-1:0] x4;
      logic [COORD_W-1:0] y4;
   } req_type;

   typedef struct packed {
      logic                tracker_enable;
      logic                motors_stop;
      logic [1:0]          load_target;
      logic [COORD_W-1:0]  target_x;
      logic [COORD_W-1:0]  target_y;
      logic                run_tracking;
      logic                is_running;
      logic                is_finished;
      logic [WP_IDX_W-1:0] waypoint_index;
      logic                is_holding;
      logic                packet_accepted;
      logic                targets_loaded;
   } rsp_type;

   typedef logic [MAX_WAYPOINTS-1:0][WP_W-1:0] wp_set_type;

   typedef struct packed {
      logic                wr_en;
      logic [WP_IDX_W-1:0] rd_idx;
   } store_ctl_type;

endpackage

[sv/wds_waypoint_store.sv]
// -----------------------------------------------------------------------------
// wds_waypoint_store
// waypoint registers, whole set written by a packet, one entry read
// -----------------------------------------------------------------------------
module wds_waypoint_store
   import wds_pkg::*;
#(
   parameter int NUM_WAYPOINTS = DEFAULT_NUM_WAYPOINTS
) (
   input  logic          clock,
   input  store_ctl_type store_ctl,
   input  wp_set_type    wr_data,
   output logic [WP_W-1:0] rd_data
);

   localparam int IDX_W = (NUM_WAYPOINTS > 1) ? $clog2(NUM_WAYPOINTS) : 1;

   logic [WP_W-1:0] mem_ff [NUM_WAYPOINTS];

   always_ff @(posedge clock) begin
      if (store_ctl.wr_en) begin
         for (int i = 0; i < NUM_WAYPOINTS; i++) begin
            mem_ff[i] <= wr_data[i];
         end
      end
   end

   always_comb begin
      if (store_ctl.rd_idx < WP_IDX_W'(NUM_WAYPOINTS)) begin
         rd_data = mem_ff[store_ctl.rd_idx[IDX_W-1:0]];
      end else begin
         rd_data = '0;
      end
   end

endmodule

[sv/wds_control.sv]
// -----------------------------------------------------------------------------
// wds_control
// tour state registers and single pass next state and result logic
// -----------------------------------------------------------------------------
`include "waypoint_dwell_sequencer_assert.svh"

module wds_control
   import wds_pkg::*;
#(
   parameter int NUM_WAYPOINTS = DEFAULT_NUM_WAYPOINTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_type            item,
   input  logic [HOLD_W-1:0]  hold_ticks,
   input  logic [COORD_W-1:0] image_size,
   output store_ctl_type      store_ctl,
   output wp_set_type         wr_data,
   input  logic [WP_W-1:0]    rd_data,
   output rsp_type            result
);

   logic                sv_ff,   sv_in;
   logic                run_ff,  run_in;
   logic                ta_ff,   ta_in;
   logic                done_ff, done_in;
   logic                en_ff,   en_in;
   logic [WP_IDX_W-1:0] cw_ff,   cw_in;
   logic [HOLD_W-1:0]   dc_ff,   dc_in;

   logic [HOLD_W-1:0]   dc_dec;
   logic [WP_IDX_W:0]   cw_next_wide;
   logic                pkt_ok;
   logic                stop;
   load_type            load;
   logic [COORD_W-1:0]  tx;
   logic [COORD_W-1:0]  ty;
   logic                run_step;
   logic                acc;
   logic [WP_W-1:0]     pkt_sel;

   assign wr_data[0] = {item.x0, item.y0};
   assign wr_data[1] = {item.x1, item.y1};
   assign wr_data[2] = {item.x2, item.y2};
   assign wr_data[3] = {item.x3, item.y3};
   assign wr_data[4] = {item.x4, item.y4};

   assign dc_dec       = dc_ff - HOLD_W'(1);
   assign cw_next_wide = {1'b0, cw_ff} + (WP_IDX_W + 1)'(1);
   assign pkt_sel      = (cw_ff < WP_IDX_W'(MAX_WAYPOINTS)) ? wr_data[cw_ff] : '0;

   always_comb begin
      pkt_ok = 1'b1;
      for (int i = 0; i < MAX_WAYPOINTS; i++) begin
         if (i < NUM_WAYPOINTS) begin
            if (wr_data[i][WP_W-1:COORD_W] >= image_size ||
                wr_data[i][COORD_W-1:0] >= image_size) begin
               pkt_ok = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (item.func == FUNC_TICK && dc_ff != '0) begin
         store_ctl.rd_idx = cw_next_wide[WP_IDX_W-1:0];
      end else if (item.func == FUNC_START) begin
         store_ctl.rd_idx = '0;
      end else begin
         store_ctl.rd_idx = cw_ff;
      end
      store_ctl.wr_en = fire && item.func == FUNC_PACKET && pkt_ok;
   end

   always_comb begin
      sv_in    = sv_ff;
      run_in   = run_ff;
      ta_in    = ta_ff;
      done_in  = done_ff;
      en_in    = en_ff;
      cw_in    = cw_ff;
      dc_in    = dc_ff;
      stop     = 1'b0;
      load     = LOAD_NONE;
      tx       = '0;
      ty       = '0;
      run_step = 1'b0;
      acc      = 1'b0;
      case (item.func)
         FUNC_TICK: begin
            if (run_ff) begin
               if (dc_ff != '0) begin
                  en_in = 1'b0;
                  ta_in = 1'b0;
                  stop  = 1'b1;
                  dc_in = dc_dec;
                  if (dc_dec == '0) begin
                     if (cw_next_wide < (WP_IDX_W + 1)'(NUM_WAYPOINTS)) begin
                        cw_in = cw_next_wide[WP_IDX_W-1:0];
                        load  = LOAD_SET;
                        tx    = rd_data[WP_W-1:COORD_W];
                        ty    = rd_data[COORD_W-1:0];
                        en_in = 1'b1;
                        ta_in = 1'b1;
                     end else begin
                        done_in = 1'b1;
                        run_in  = 1'b0;
                     end
                  end
               end else if (!sv_ff || done_ff) begin
                  en_in = 1'b0;
                  ta_in = 1'b0;
                  stop  = 1'b1;
               end else begin
                  if (!ta_ff) begin
                     load  = LOAD_SET;
                     tx    = rd_data[WP_W-1:COORD_W];
                     ty    = rd_data[COORD_W-1:0];
                     en_in = 1'b1;
                     ta_in = 1'b1;
                  end
                  run_step = 1'b1;
                  if (item.reached) begin
                     en_in = 1'b0;
                     ta_in = 1'b0;
                     stop  = 1'b1;
                     dc_in = hold_ticks;
                  end
               end
            end
         end
         FUNC_START: begin
            run_in  = 1'b1;
            ta_in   = 1'b0;
            cw_in   = '0;
            done_in = 1'b0;
            dc_in   = '0;
            if (sv_ff) begin
               load  = LOAD_SET;
               tx    = rd_data[WP_W-1:COORD_W];
               ty    = rd_data[COORD_W-1:0];
               en_in = 1'b1;
               ta_in = 1'b1;
            end
         end
         FUNC_STOP: begin
            run_in = 1'b0;
            dc_in  = '0;
            en_in  = 1'b0;
            ta_in  = 1'b0;
            stop   = 1'b1;
         end
         default: begin
            if (pkt_ok) begin
               sv_in = 1'b1;
               acc   = 1'b1;
               if (run_ff && !done_ff && cw_ff < WP_IDX_W'(NUM_WAYPOINTS)) begin
                  load = LOAD_UPDATE;
                  tx   = pkt_sel[WP_W-1:COORD_W];
                  ty   = pkt_sel[COORD_W-1:0];
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff   <= 1'b0;
         run_ff  <= 1'b0;
         ta_ff   <= 1'b0;
         done_ff <= 1'b0;
         en_ff   <= 1'b0;
         cw_ff   <= '0;
         dc_ff   <= '0;
      end else if (fire) begin
         sv_ff   <= sv_in;
         run_ff  <= run_in;
         ta_ff   <= ta_in;
         done_ff <= done_in;
         en_ff   <= en_in;
         cw_ff   <= cw_in;
         dc_ff   <= dc_in;
      end
   end

   always_comb begin
      result.tracker_enable  = en_in;
      result.motors_stop     = stop;
      result.load_target     = load;
      result.target_x        = tx;
      result.target_y        = ty;
      result.run_tracking    = run_step;
      result.is_running      = run_in;
      result.is_finished     = done_in;
      result.waypoint_index  = cw_in;
      result.is_holding      = (dc_in != '0);
      result.packet_accepted = acc;
      result.targets_loaded  = sv_in;
   end

   `WDS_ASSERT_IMPL(a_dwell_in_tour, clock, reset, dc_ff != '0, run_ff, "dwell outside a tour")
   `WDS_ASSERT_IMPL(a_done_not_running, clock, reset, done_ff, !run_ff, "finished tour still running")
   `WDS_ASSERT(a_enable_tracks, clock, reset, en_ff == ta_ff, "enable level and tracking differ")
   `WDS_ASSERT(a_index_range, clock, reset, cw_ff < WP_IDX_W'(NUM_WAYPOINTS), "waypoint index out of range")
   `WDS_ASSERT(a_store_marks_valid, clock, reset, store_ctl.wr_en |=> sv_ff, "store written but not valid")

endmodule

[sv/waypoint_dwell_sequencer.sv]
// -----------------------------------------------------------------------------
// waypoint_dwell_sequencer
// steps a tracker through stored waypoints with a dwell at each one
// -----------------------------------------------------------------------------
// req_* carries one item per transaction (tick, start, stop or target packet);
// rsp_* returns exactly one result per item, in order. both channels move a
// transaction when valid is high and stall is low.
// an item is registered at acceptance and its result is registered in the
// output register when that item fires, which a held result can delay.
// one item per cycle is sustained while rsp_stall is low; the only loop is the
// tour state update, which closes between the input and result registers.
// when rsp_stall holds a result, one more item waits in the input register
// and req_stall rises only once that register is also full.
// csr_* writes hold_ticks (index 0) or image_size (index 1); csr_ready is
// always high. write only while no transaction is in flight.
// reset (synchronous, active high) empties both registers, returns the
// registers to 100 and 240 and clears all tour state; stored waypoints read
// as unknown until a packet is accepted.
// -----------------------------------------------------------------------------
module waypoint_dwell_sequencer
   import wds_pkg::*;
#(
   parameter int NUM_WAYPOINTS = DEFAULT_NUM_WAYPOINTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic               in_valid_ff;
   req_type            in_data_ff;
   logic               out_valid_ff;
   rsp_type            out_data_ff;
   logic [HOLD_W-1:0]  hold_ticks_ff;
   logic [COORD_W-1:0] image_size_ff;

   logic               fire;
   logic               req_take;
   store_ctl_type      store_ctl;
   wp_set_type         wr_data;
   logic [WP_W-1:0]    rd_data;
   rsp_type            result;

   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= HOLD_TICKS_RESET;
         image_size_ff <= IMAGE_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOLD_TICKS: hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
            CSR_IMAGE_SIZE: image_size_ff <= csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   wds_control #(
      .NUM_WAYPOINTS (NUM_WAYPOINTS)
   ) u_control (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .item       (in_data_ff),
      .hold_ticks (hold_ticks_ff),
      .image_size (image_size_ff),
      .store_ctl  (store_ctl),
      .wr_data    (wr_data),
      .rd_data    (rd_data),
      .result     (result)
   );

   wds_waypoint_store #(
      .NUM_WAYPOINTS (NUM_WAYPOINTS)
   ) u_store (
      .clock     (clock),
      .store_ctl (store_ctl),
      .wr_data   (wr_data),
      .rd_data   (rd_data)
   );

endmodule
